### src/pbrle_pkg.sv
// ============================================================================
// pbrle_pkg
// Shared sizes and channel payload types of the PackBits run-length encoder.
// ============================================================================
`default_nettype none

package pbrle_pkg;

    // Largest literal group and largest run, in bytes
    localparam int MAX_LITERAL = 32;
    localparam int MAX_RUN     = 128;

    // Literal store addressing and literal byte count
    localparam int LIT_AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int LIT_CW = $clog2(MAX_LITERAL + 1);

    // Run length counter
    localparam int RL_W = $clog2(MAX_RUN + 1);

    // Code values
    localparam logic [8:0] RUN_BASE   = 9'd257;
    localparam logic [7:0] END_MARKER = 8'd128;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_item;
    } pbrle_in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       burst_end;
        logic       stream_end;
    } pbrle_out_t;

endpackage

`default_nettype wire

### src/pbrle_in_if.sv
// ============================================================================
// pbrle_in_if
// Valid/ready channel that carries one pixel byte per transaction.
// ============================================================================
`default_nettype none

interface pbrle_in_if
    import pbrle_pkg::*;
;
    logic      valid;
    logic      ready;
    pbrle_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/pbrle_out_if.sv
// ============================================================================
// pbrle_out_if
// Valid/ready channel that carries one PackBits code byte per transaction.
// ============================================================================
`default_nettype none

interface pbrle_out_if
    import pbrle_pkg::*;
;
    logic       valid;
    logic       ready;
    pbrle_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### src/pbrle_ram.sv
// ============================================================================
// pbrle_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module pbrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/packbits_run_length_encoder_unit.sv
// ============================================================================
// packbits_run_length_encoder_unit
// PackBits encoder: pixel bytes in, run/literal code bytes and end marker out.
// ============================================================================
//
// The unit takes one pixel byte per transaction on pixels and emits PackBits
// code bytes on codes, one byte per transaction. Two or more equal bytes form
// a run, coded as 257 minus the length followed by the byte; runs are capped
// at MAX_RUN bytes. Other bytes collect in a literal store (a small RAM) and
// are coded as length minus one followed by the bytes, in groups of at most
// MAX_LITERAL bytes. After a byte marked final_item, everything pending is
// flushed, the end marker 128 follows with stream_end set, and the encoder
// returns to its reset state. burst_end marks the last code byte caused by an
// input byte; an input byte may cause no code byte at all. One byte is worked
// on at a time; a byte that emits nothing passes only the decision state
// before the next accept. A run adds a header and a value step; a literal
// flush adds a header step and data steps, the group streamed out of the
// literal RAM through its registered read port one byte per cycle while codes
// does not stall. A final byte adds a closing decision and the end marker.
// Code bytes leave through an output register, so a new pixel byte is accepted
// while the last code byte waits; codes backpressure stalls emitting steps only.
// ============================================================================
`default_nettype none

module packbits_run_length_encoder_unit
    import pbrle_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pbrle_in_if.sink   pixels,
    pbrle_out_if.source codes
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_FL_HDR,
        S_FL_DATA,
        S_RUN_HDR,
        S_RUN_VAL,
        S_TAIL,
        S_END
    } state_t;

    // Encoder state
    state_t           state_reg,     state_next;
    logic             phase_reg,     phase_next;     // 1: closing a final byte
    logic             last_reg,      last_next;
    logic [7:0]       byte_reg,      byte_next;
    logic [LIT_CW-1:0] lc_reg,       lc_next;        // literal bytes held
    logic [7:0]       rv_reg,        rv_next;        // pending byte value
    logic [RL_W-1:0]  rl_reg,        rl_next;        // pending run length
    logic [LIT_CW-1:0] k_reg,        k_next;         // flush read index

    // Output register
    logic             out_valid_reg, out_valid_next;
    pbrle_out_t       out_item_reg,  out_item_next;

    // Literal RAM access
    logic             ram_we;
    logic [LIT_CW-1:0] rd_cnt;
    logic [7:0]       ram_rdata;

    logic             emit_ok;
    logic             emit;
    pbrle_out_t       emit_item;
    logic [LIT_CW-1:0] lc_inc;
    logic [LIT_CW-1:0] lc_last;
    logic             byte_eq;

    pbrle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LITERAL)
    ) u_lit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lc_reg[LIT_AW-1:0]),
        .wdata (rv_reg),
        .raddr (rd_cnt[LIT_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pixels.ready  = (state_reg == S_IDLE);
    assign codes.valid   = out_valid_reg;
    assign codes.payload = out_item_reg;

    // A code byte may be produced when the output register is free or drains
    assign emit_ok = !out_valid_reg || codes.ready;
    assign lc_inc  = lc_reg + LIT_CW'(1);
    assign lc_last = lc_reg - LIT_CW'(1);
    assign byte_eq = (byte_reg == rv_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        byte_next  = byte_reg;
        lc_next    = lc_reg;
        rv_next    = rv_reg;
        rl_next    = rl_reg;
        k_next     = k_reg;
        ram_we     = 1'b0;
        rd_cnt     = k_reg;
        emit       = 1'b0;
        emit_item  = '{code_byte: 8'd0, burst_end: 1'b0, stream_end: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (pixels.valid)
                begin
                    byte_next  = pixels.payload.data_byte;
                    last_next  = pixels.payload.final_item;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                phase_next = 1'b0;
                if (rl_reg == '0)
                begin
                    // Nothing pending: the byte becomes the pending one
                    rv_next    = byte_reg;
                    rl_next    = RL_W'(1);
                    state_next = last_reg ? S_TAIL : S_IDLE;
                end
                else if (byte_eq && rl_reg >= RL_W'(MAX_RUN))
                begin
                    // Full run: emit it, the byte restarts a run of one
                    state_next = S_RUN_HDR;
                end
                else if (byte_eq && rl_reg == RL_W'(1))
                begin
                    // A pair starts a run: the literal group so far goes first
                    rl_next = RL_W'(2);
                    if (lc_reg != '0)
                    begin
                        state_next = S_FL_HDR;
                    end
                    else
                    begin
                        state_next = last_reg ? S_TAIL : S_IDLE;
                    end
                end
                else if (byte_eq)
                begin
                    rl_next    = rl_reg + RL_W'(1);
                    state_next = last_reg ? S_TAIL : S_IDLE;
                end
                else if (rl_reg >= RL_W'(2))
                begin
                    // Run broken by a new byte: emit it first
                    state_next = S_RUN_HDR;
                end
                else
                begin
                    // Single byte joins the literal group
                    ram_we  = 1'b1;
                    lc_next = lc_inc;
                    rv_next = byte_reg;
                    rl_next = RL_W'(1);
                    if (lc_inc == LIT_CW'(MAX_LITERAL))
                    begin
                        state_next = S_FL_HDR;
                    end
                    else
                    begin
                        state_next = last_reg ? S_TAIL : S_IDLE;
                    end
                end
            end

            S_FL_HDR:
            begin
                rd_cnt = '0;
                if (emit_ok)
                begin
                    emit               = 1'b1;
                    emit_item.code_byte = 8'(lc_last);
                    k_next             = '0;
                    state_next         = S_FL_DATA;
                end
            end

            S_FL_DATA:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.code_byte = ram_rdata;
                    if (k_reg == lc_last)
                    begin
                        emit_item.burst_end = !phase_reg && !last_reg;
                        lc_next = '0;
                        if (!phase_reg)
                        begin
                            state_next = last_reg ? S_TAIL : S_IDLE;
                        end
                        else
                        begin
                            state_next = (rl_reg >= RL_W'(2)) ? S_RUN_HDR : S_END;
                        end
                    end
                    else
                    begin
                        // Advance the read one entry ahead of the next emit
                        k_next = k_reg + LIT_CW'(1);
                        rd_cnt = k_reg + LIT_CW'(1);
                    end
                end
            end

            S_RUN_HDR:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.code_byte = 8'(RUN_BASE - 9'(rl_reg));
                    state_next          = S_RUN_VAL;
                end
            end

            S_RUN_VAL:
            begin
                if (emit_ok)
                begin
                    emit                = 1'b1;
                    emit_item.code_byte = rv_reg;
                    emit_item.burst_end = !phase_reg && !last_reg;
                    if (!phase_reg)
                    begin
                        rv_next    = byte_reg;
                        rl_next    = RL_W'(1);
                        state_next = last_reg ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end

            S_TAIL:
            begin
                // Final byte seen: flush whatever is pending
                phase_next = 1'b1;
                if (rl_reg == RL_W'(1))
                begin
                    ram_we     = 1'b1;
                    lc_next    = lc_inc;
                    state_next = S_FL_HDR;
                end
                else if (lc_reg != '0)
                begin
                    state_next = S_FL_HDR;
                end
                else
                begin
                    state_next = S_RUN_HDR;
                end
            end

            S_END:
            begin
                if (emit_ok)
                begin
                    emit                 = 1'b1;
                    emit_item.code_byte  = END_MARKER;
                    emit_item.burst_end  = 1'b1;
                    emit_item.stream_end = 1'b1;
                    lc_next              = '0;
                    rv_next              = 8'd0;
                    rl_next              = '0;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: load on emit, drop once taken
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = emit_item;
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            last_reg      <= 1'b0;
            byte_reg      <= 8'd0;
            lc_reg        <= '0;
            rv_reg        <= 8'd0;
            rl_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '{code_byte: 8'd0, burst_end: 1'b0, stream_end: 1'b0};
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            byte_reg      <= byte_next;
            lc_reg        <= lc_next;
            rv_reg        <= rv_next;
            rl_reg        <= rl_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

`default_nettype wire

### verif/tb_packbits_run_length_encoder_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_packbits_run_length_encoder_unit
// Self-checking bench for the PackBits encoder: images of pixel bytes are sent
// on the pixel channel, code bytes are predicted per accepted byte and matched
// in order against what leaves the code channel, both sides with random idling.
// ============================================================================

module tb_packbits_run_length_encoder_unit;
    import pbrle_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 40;     // quiet cycles after the last code byte
    localparam int RANDOM_ITEMS   = 320;

    logic clk = 1'b0;
    logic rst_n;

    pbrle_in_if  pix_if ();
    pbrle_out_if code_if ();

    packbits_run_length_encoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pix_if),
        .codes  (code_if)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Encoder prediction: mirror of the literal store, pending byte and run
    // ------------------------------------------------------------------------
    logic [7:0]  lit_bytes [MAX_LITERAL];
    int unsigned lit_len;
    logic [7:0]  run_byte;
    int unsigned run_len;

    pbrle_out_t  step_codes[$];       // code bytes decided by the byte in hand
    pbrle_out_t  expected_codes[$];   // code bytes still owed by the encoder
    pbrle_in_t   pending_pixels[$];   // pixel bytes not yet offered

    int mismatches = 0;

    function automatic void put_code(logic [7:0] value, logic is_end);
        pbrle_out_t c;
        c.code_byte  = value;
        c.burst_end  = 1'b0;
        c.stream_end = is_end;
        step_codes.insert(step_codes.size(), c);
    endfunction

    function automatic void flush_literals();
        if (lit_len == 0)
            return;
        put_code(8'(lit_len - 1), 1'b0);
        for (int k = 0; k < lit_len; k++)
            put_code(lit_bytes[k], 1'b0);
        lit_len = 0;
    endfunction

    function automatic void add_literal(logic [7:0] value);
        lit_bytes[lit_len] = value;
        lit_len++;
        // Literal cap: a full group goes out at once
        if (lit_len >= MAX_LITERAL)
            flush_literals();
    endfunction

    function automatic void emit_run();
        logic [8:0] header;
        header = RUN_BASE - 9'(run_len);
        put_code(header[7:0], 1'b0);
        put_code(run_byte, 1'b0);
    endfunction

    function automatic void clear_encoder();
        lit_len  = 0;
        run_byte = '0;
        run_len  = 0;
    endfunction

    // Work out the code bytes caused by one accepted pixel byte
    function automatic void encode_byte(logic [7:0] b, logic last);
        step_codes.delete();
        if (run_len == 0)
        begin
            run_byte = b;
            run_len  = 1;
        end
        else if (b == run_byte)
        begin
            if (run_len >= MAX_RUN)
            begin
                // Run cap: close the full run, this byte starts a new one
                emit_run();
                run_len = 1;
            end
            else
            begin
                // Run after literal: the held group goes out before the run grows
                if (run_len == 1)
                    flush_literals();
                run_len++;
            end
        end
        else
        begin
            if (run_len >= 2)
                emit_run();
            else
                add_literal(run_byte);
            run_byte = b;
            run_len  = 1;
        end

        if (last)
        begin
            // End of data: flush everything, then the end marker
            if (run_len == 1)
            begin
                add_literal(run_byte);
                flush_literals();
            end
            else if (run_len >= 2)
            begin
                flush_literals();
                emit_run();
            end
            put_code(END_MARKER, 1'b1);
            clear_encoder();
        end

        if (step_codes.size() > 0)
            step_codes[step_codes.size() - 1].burst_end = 1'b1;
        foreach (step_codes[i])
            expected_codes.insert(expected_codes.size(), step_codes[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Idle pattern: mostly short gaps, a few long ones, and calm stretches
    // ------------------------------------------------------------------------
    function automatic int pick_gap(ref bit calm);
        int r;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    pbrle_in_t image_bytes[$];

    task automatic add_byte(logic [7:0] b);
        pbrle_in_t item;
        item.data_byte  = b;
        item.final_item = 1'b0;
        image_bytes.insert(image_bytes.size(), item);
    endtask

    // Close the image under construction: mark its last byte and queue it
    task automatic close_image();
        if (image_bytes.size() == 0)
            return;
        image_bytes[image_bytes.size() - 1].final_item = 1'b1;
        foreach (image_bytes[i])
            pending_pixels.insert(pending_pixels.size(), image_bytes[i]);
        image_bytes.delete();
    endtask

    task automatic add_run(logic [7:0] b, int len);
        for (int i = 0; i < len; i++)
            add_byte(b);
    endtask

    // Literal stretch: neighboring bytes always differ
    task automatic add_literal_stretch(int len);
        logic [7:0] prev;
        logic [7:0] b;
        prev = 8'($urandom);
        add_byte(prev);
        for (int i = 1; i < len; i++)
        begin
            b = 8'($urandom);
            if (b == prev)
                b = ~b;
            add_byte(b);
            prev = b;
        end
    endtask

    // Noise over a tiny alphabet: equal pairs and short runs appear by chance
    task automatic add_noise(int len);
        logic [7:0] base;
        base = 8'($urandom);
        for (int i = 0; i < len; i++)
            add_byte(base ^ 8'($urandom_range(0, 1)));
    endtask

    task automatic add_random_image();
        int segs;
        int kind;
        segs = $urandom_range(1, 6);
        for (int s = 0; s < segs; s++)
        begin
            kind = $urandom_range(0, 29);
            if (kind < 10)
                add_literal_stretch(($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                                                : $urandom_range(1, 8));
            else if (kind < 19)
                add_run(8'($urandom), $urandom_range(2, 6));
            else if (kind == 19)
                add_run(8'($urandom), $urandom_range(126, 131));
            else if (kind < 26)
                add_noise($urandom_range(1, 10));
            else
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    add_byte(8'($urandom));
        end
        close_image();
    endtask

    task automatic build_stimulus();
        int start_size;

        // Directed: single-byte images at both extremes of the byte
        add_byte(8'h00);
        close_image();
        add_byte(8'hFF);
        close_image();
        // Run of two closed by the final byte
        add_run(8'h07, 2);
        close_image();
        // Literal group closed by the final byte
        add_byte(8'h01);
        add_byte(8'h02);
        add_byte(8'h03);
        close_image();
        // Literal, then a run that flushes it, then a lone byte at the end
        add_byte(8'h05);
        add_run(8'h09, 3);
        add_byte(8'h04);
        close_image();
        // Two runs back to back
        add_run(8'h03, 2);
        add_run(8'h08, 2);
        close_image();
        // Literal ended by a run that is closed by the final byte
        add_byte(8'h80);
        add_byte(8'h01);
        add_run(8'h02, 2);
        close_image();

        start_size = pending_pixels.size();

        // Run cap and literal cap in one well-formed image
        add_run(8'($urandom), MAX_RUN + 1);
        add_literal_stretch(MAX_LITERAL + 1);
        close_image();
        add_run(8'($urandom), MAX_RUN);
        close_image();

        while (pending_pixels.size() - start_size < RANDOM_ITEMS)
            add_random_image();
    endtask

    // ------------------------------------------------------------------------
    // Pixel driver: offer queued bytes, predict on every accepted transaction
    // ------------------------------------------------------------------------
    int in_gap  = 0;
    bit in_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid   <= 1'b0;
            pix_if.payload <= '0;
            in_gap = 0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
                encode_byte(pix_if.payload.data_byte, pix_if.payload.final_item);

            if (pix_if.valid && !pix_if.ready)
            begin
                // hold the offered byte until it is taken
            end
            else if (in_gap > 0)
            begin
                in_gap--;
                pix_if.valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                pix_if.payload <= pending_pixels.pop_front();
                pix_if.valid   <= 1'b1;
                in_gap = pick_gap(in_calm);
            end
            else
            begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Code monitor: random backpressure, compare each transaction in order
    // ------------------------------------------------------------------------
    int out_gap  = 0;
    bit out_calm = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        pbrle_out_t want;
        pbrle_out_t got;
        if (!rst_n)
        begin
            code_if.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (code_if.valid && code_if.ready)
            begin
                got = code_if.payload;
                if (expected_codes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected code byte %02h burst_end %0b stream_end %0b",
                                 $realtime, got.code_byte, got.burst_end, got.stream_end);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.code_byte !== want.code_byte ||
                        got.burst_end !== want.burst_end ||
                        got.stream_end !== want.stream_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: code mismatch, expected %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, want.code_byte, want.burst_end,
                                     want.stream_end, got.code_byte, got.burst_end,
                                     got.stream_end);
                    end
                end
            end

            // Drop ready for a random gap, otherwise take codes freely
            if (out_gap > 0)
            begin
                out_gap--;
                code_if.ready <= 1'b0;
            end
            else
            begin
                code_if.ready <= 1'b1;
                out_gap = pick_gap(out_calm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // ------------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (code_if.valid && code_if.ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, stimulus, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        clear_encoder();

        build_stimulus();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every pixel byte has been taken
        while (pending_pixels.size() > 0 || pix_if.valid)
            @(posedge clk);
        // Wait for every owed code byte, then watch for strays
        while (expected_codes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_codes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
